// ===== sv/deq_pkg.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue package
// Shared types, operation and status codes, and default sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed widths of the channel fields.
   localparam int PORT_WIDTH  = 32;
   localparam int KIND_WIDTH  = 3;
   localparam int COUNT_WIDTH = 11;
   localparam int STATUS_WIDTH = 2;

   localparam logic [KIND_WIDTH-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_POP_BACK   = 3'd3;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW  = 2'd2;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic load_front;
      logic take_front;
      logic load_back;
      logic take_back;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== sv/deq_cell.sv =====
// ---------------------------------------------------------------------------
// Deque storage cell
// Holds one entry; shifts with its neighbors and takes or drops the tail.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_cell #(
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire deq_pkg::cell_ctl_type ctl,
   input  wire logic [DATA_WIDTH-1:0] push_value,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic                  left_valid,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   input  wire logic                  right_valid,
   output logic      [DATA_WIDTH-1:0] data,
   output logic                       valid,
   output logic      [DATA_WIDTH-1:0] tail_data
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;
   logic                  is_tail;

   // Entries stay packed toward the front, so the tail is the last valid cell.
   assign is_tail = valid_ff & ~right_valid;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctl.load_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctl.take_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctl.load_back) begin
         if (!valid_ff && left_valid) begin
            data_in  = push_value;
            valid_in = 1'b1;
         end
      end else if (ctl.take_back) begin
         if (is_tail) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign valid     = valid_ff;
   assign tail_data = is_tail ? data_ff : '0;

endmodule

`default_nettype wire

// ===== sv/deq_tail_tree.sv =====
// ---------------------------------------------------------------------------
// Deque tail tree
// Registered OR tree that collects the word of the single tail cell.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_tail_tree #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic [DATA_WIDTH-1:0] tail_data [DEPTH],
   output logic      [DATA_WIDTH-1:0] root
);

   localparam int LEVELS = $clog2(DEPTH);
   localparam int LEAVES = 1 << LEVELS;

   // Heap layout: node k has children 2k and 2k+1, leaves start at LEAVES.
   logic [DATA_WIDTH-1:0] node_ff [2*LEAVES-1:1];

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < DEPTH) begin : g_used
         always_ff @(posedge clock) begin
            node_ff[LEAVES+j] <= tail_data[j];
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            node_ff[LEAVES+j] <= '0;
         end
      end
   end

   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      always_ff @(posedge clock) begin
         node_ff[k] <= node_ff[2*k] | node_ff[2*k+1];
      end
   end

   assign root = node_ff[1];

endmodule

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// The result word is presented in the cycle after the item is taken, except
// for a pop from the back that leaves the queue non-empty: that result waits
// until the new tail word has settled through the registered tail tree.
// Every other item sustains one word per cycle while rsp_stall is low.
// Reset is synchronous and empties the queue at once; no clearing pass.
// ---------------------------------------------------------------------------
// Double-ended queue
// Bounded deque held in a chain of shifting cells, front at cell zero.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [deq_pkg::KIND_WIDTH-1:0]     req_kind,
   input  wire logic [deq_pkg::PORT_WIDTH-1:0]     req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [deq_pkg::PORT_WIDTH-1:0]     rsp_popped_value,
   output logic                                    rsp_popped_valid,
   output logic      [deq_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic      [deq_pkg::COUNT_WIDTH-1:0]    rsp_count,
   output logic                                    rsp_is_empty,
   output logic      [deq_pkg::PORT_WIDTH-1:0]     rsp_front_value,
   output logic      [deq_pkg::PORT_WIDTH-1:0]     rsp_back_value
);

   localparam int CW        = $clog2(DEPTH + 1);
   localparam int LEVELS    = $clog2(DEPTH);
   localparam int WAIT_LAST = LEVELS + 1;
   localparam int WW        = $clog2(WAIT_LAST + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WAIT = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [WW-1:0]           wait_ff, wait_in;
   logic [DATA_WIDTH-1:0]   back_ff, back_in;
   logic [DATA_WIDTH-1:0]   popped_ff, popped_in;
   logic                    pvalid_ff, pvalid_in;
   logic [deq_pkg::STATUS_WIDTH-1:0] status_ff, status_in;

   deq_pkg::cell_ctl_type   ctl;
   logic                    req_accept;
   logic                    is_full, is_empty;
   logic [63:0]             value_wide, front_wide, back_wide, popped_wide, count_wide;
   logic [DATA_WIDTH-1:0]   push_value;
   logic [DATA_WIDTH-1:0]   tree_root;

   logic [DATA_WIDTH-1:0]   cell_data  [DEPTH];
   logic                    cell_valid [DEPTH];
   logic [DATA_WIDTH-1:0]   cell_tail  [DEPTH];
   logic [DATA_WIDTH-1:0]   left_data  [DEPTH];
   logic                    left_valid [DEPTH];
   logic [DATA_WIDTH-1:0]   right_data [DEPTH];
   logic                    right_valid[DEPTH];

   assign value_wide = 64'(req_value);
   assign push_value = value_wide[DATA_WIDTH-1:0];

   // A waiting result may be taken in the same cycle the next word enters.
   assign req_stall  = !((state_ff == S_IDLE) || ((state_ff == S_RESP) && !rsp_stall));
   assign req_accept = req_valid && !req_stall;

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      ctl       = '0;
      state_in  = state_ff;
      count_in  = count_ff;
      wait_in   = wait_ff;
      back_in   = back_ff;
      popped_in = '0;
      pvalid_in = 1'b0;
      status_in = deq_pkg::STATUS_OK;
      case (state_ff)
         S_IDLE, S_RESP: begin
            if ((state_ff == S_RESP) && !rsp_stall) begin
               state_in = S_IDLE;
            end
            if (req_accept) begin
               state_in = S_RESP;
               case (req_kind)
                  deq_pkg::KIND_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = deq_pkg::STATUS_OVERFLOW;
                     end else begin
                        ctl.load_front = 1'b1;
                        count_in       = count_ff + CW'(1);
                        if (is_empty) begin
                           back_in = push_value;
                        end
                     end
                  end
                  deq_pkg::KIND_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = deq_pkg::STATUS_OVERFLOW;
                     end else begin
                        ctl.load_back = 1'b1;
                        count_in      = count_ff + CW'(1);
                        back_in       = push_value;
                     end
                  end
                  deq_pkg::KIND_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = deq_pkg::STATUS_UNDERFLOW;
                     end else begin
                        ctl.take_front = 1'b1;
                        popped_in      = cell_data[0];
                        pvalid_in      = 1'b1;
                        count_in       = count_ff - CW'(1);
                     end
                  end
                  deq_pkg::KIND_POP_BACK: begin
                     if (is_empty) begin
                        status_in = deq_pkg::STATUS_UNDERFLOW;
                     end else begin
                        ctl.take_back = 1'b1;
                        popped_in     = back_ff;
                        pvalid_in     = 1'b1;
                        count_in      = count_ff - CW'(1);
                        // The new tail word comes from the tree once it settles.
                        if (count_ff != CW'(1)) begin
                           state_in = S_WAIT;
                           wait_in  = WW'(WAIT_LAST);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WAIT: begin
            if (wait_ff == '0) begin
               back_in  = tree_root;
               state_in = S_RESP;
            end else begin
               wait_in = wait_ff - WW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         wait_ff  <= wait_in;
      end
      back_ff <= back_in;
      if (req_accept) begin
         popped_ff <= popped_in;
         pvalid_ff <= pvalid_in;
         status_ff <= status_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_data[i]  = push_value;
         assign left_valid[i] = 1'b1;
      end else begin : g_inner_left
         assign left_data[i]  = cell_data[i-1];
         assign left_valid[i] = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data[i]  = '0;
         assign right_valid[i] = 1'b0;
      end else begin : g_inner_right
         assign right_data[i]  = cell_data[i+1];
         assign right_valid[i] = cell_valid[i+1];
      end

      deq_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .push_value (push_value),
         .left_data  (left_data[i]),
         .left_valid (left_valid[i]),
         .right_data (right_data[i]),
         .right_valid(right_valid[i]),
         .data       (cell_data[i]),
         .valid      (cell_valid[i]),
         .tail_data  (cell_tail[i])
      );
   end

   deq_tail_tree #(
      .DEPTH     (DEPTH),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_tail_tree (
      .clock    (clock),
      .tail_data(cell_tail),
      .root     (tree_root)
   );

   assign front_wide  = 64'(cell_data[0]);
   assign back_wide   = 64'(back_ff);
   assign popped_wide = 64'(popped_ff);
   assign count_wide  = 64'(count_ff);

   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_popped_value = popped_wide[deq_pkg::PORT_WIDTH-1:0];
   assign rsp_popped_valid = pvalid_ff;
   assign rsp_status       = status_ff;
   assign rsp_count        = count_wide[deq_pkg::COUNT_WIDTH-1:0];
   assign rsp_is_empty     = is_empty;
   assign rsp_front_value  = is_empty ? '0 : front_wide[deq_pkg::PORT_WIDTH-1:0];
   assign rsp_back_value   = is_empty ? '0 : back_wide[deq_pkg::PORT_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== sv/deq_checker.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [deq_pkg::PORT_WIDTH-1:0]   rsp_popped_value,
   input wire logic                             rsp_popped_valid,
   input wire logic [deq_pkg::STATUS_WIDTH-1:0] rsp_status,
   input wire logic [deq_pkg::COUNT_WIDTH-1:0]  rsp_count,
   input wire logic                             rsp_is_empty,
   input wire logic [deq_pkg::PORT_WIDTH-1:0]   rsp_front_value,
   input wire logic [deq_pkg::PORT_WIDTH-1:0]   rsp_back_value
);

   // A word is taken only while no result word is held back.
   a_take_only_when_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
      else $error("word taken while a result word was held back");

   a_popped_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_popped_valid |-> rsp_status == deq_pkg::STATUS_OK)
      else $error("popped word reported with an error status");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == deq_pkg::STATUS_UNDERFLOW |->
         rsp_is_empty && !rsp_popped_valid && rsp_popped_value == '0)
      else $error("underflow reported on a non-empty queue");

   a_empty_peeks_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_front_value == '0 && rsp_back_value == '0)
      else $error("empty queue shows a front or back word");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count) && $stable(rsp_back_value))
      else $error("stalled result word changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire

// ===== tb/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Double-ended queue testbench
// Drives pushes, pops and queries at both ends, and keeps its own circular
// buffer to predict every result word. Results are checked field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_double_ended_queue;

   localparam int QUEUE_DEPTH = deq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_PRINTED = 40;
   localparam logic [deq_pkg::KIND_WIDTH-1:0] KIND_QUERY = 3'd4;

   typedef logic [deq_pkg::KIND_WIDTH-1:0]  kind_type;
   typedef logic [deq_pkg::COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [deq_pkg::KIND_WIDTH-1:0] kind;
      logic [deq_pkg::PORT_WIDTH-1:0] value;
      logic                           wait_drain;
   } deque_op_type;

   typedef struct packed {
      logic [deq_pkg::PORT_WIDTH-1:0]   popped_value;
      logic                             popped_valid;
      logic [deq_pkg::STATUS_WIDTH-1:0] status;
      logic [deq_pkg::COUNT_WIDTH-1:0]  count;
      logic                             is_empty;
      logic [deq_pkg::PORT_WIDTH-1:0]   front_value;
      logic [deq_pkg::PORT_WIDTH-1:0]   back_value;
   } deque_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [deq_pkg::KIND_WIDTH-1:0] req_kind = '0;
   logic [deq_pkg::PORT_WIDTH-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [deq_pkg::PORT_WIDTH-1:0] rsp_popped_value;
   logic rsp_popped_valid;
   logic [deq_pkg::STATUS_WIDTH-1:0] rsp_status;
   logic [deq_pkg::COUNT_WIDTH-1:0] rsp_count;
   logic rsp_is_empty;
   logic [deq_pkg::PORT_WIDTH-1:0] rsp_front_value;
   logic [deq_pkg::PORT_WIDTH-1:0] rsp_back_value;

   double_ended_queue uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_popped_valid (rsp_popped_valid),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value)
   );

   always #1 clock = ~clock;

   // Items waiting to be sent and results waiting to arrive.
   deque_op_type     pending_ops[$];
   deque_result_type expected_results[$];

   // Predictor state: circular buffer, head slot and occupancy.
   logic [deq_pkg::PORT_WIDTH-1:0] model_store [QUEUE_DEPTH];
   int model_head = 0;
   int model_count = 0;

   int planned_count = 0;
   int error_count = 0;
   int cycle_count = 0;
   int words_sent = 0;
   int results_seen = 0;
   int push_hits = 0;
   int pop_hits = 0;
   int underflow_hits = 0;
   int overflow_hits = 0;
   int peak_count = 0;

   bit word_taken = 1'b0;
   bit tail_quiet = 1'b0;
   bit send_bursty = 1'b1;
   bit recv_bursty = 1'b1;
   bit long_hold_done = 1'b0;
   int send_gap = 0;
   int hold_left = 0;
   deque_op_type next_op;
   deque_result_type want;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("[%0d] mismatch in %s on result %0d: got %h, expected %h",
                  cycle_count, what, results_seen, got, exp_val);
   endtask

   function automatic deque_result_type apply_deque_op(input kind_type kind,
                                                       input logic [31:0] value);
      deque_result_type r;
      r = '0;
      r.status = deq_pkg::STATUS_OK;
      case (kind)
         deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
            if (model_count >= QUEUE_DEPTH) begin
               r.status = deq_pkg::STATUS_OVERFLOW;
               overflow_hits++;
            end else if (kind == deq_pkg::KIND_PUSH_FRONT) begin
               model_head = (model_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
               model_store[model_head] = value;
               model_count++;
               push_hits++;
            end else begin
               model_store[(model_head + model_count) % QUEUE_DEPTH] = value;
               model_count++;
               push_hits++;
            end
         end
         deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
            if (model_count == 0) begin
               r.status = deq_pkg::STATUS_UNDERFLOW;
               underflow_hits++;
            end else if (kind == deq_pkg::KIND_POP_FRONT) begin
               r.popped_value = model_store[model_head];
               r.popped_valid = 1'b1;
               model_head = (model_head + 1) % QUEUE_DEPTH;
               model_count--;
               pop_hits++;
            end else begin
               r.popped_value = model_store[(model_head + model_count - 1) % QUEUE_DEPTH];
               r.popped_valid = 1'b1;
               model_count--;
               pop_hits++;
            end
         end
         default: ;
      endcase
      if (model_count > peak_count)
         peak_count = model_count;
      r.count = count_type'(model_count);
      r.is_empty = (model_count == 0);
      if (model_count != 0) begin
         r.front_value = model_store[model_head];
         r.back_value = model_store[(model_head + model_count - 1) % QUEUE_DEPTH];
      end
      return r;
   endfunction

   // Tracks the occupancy the planned sequence will reach, so that the
   // drain phase knows when to stop.
   task automatic add_op(input kind_type kind, input logic [31:0] value, input bit drain);
      deque_op_type op;
      op.kind = kind;
      op.value = value;
      op.wait_drain = drain;
      pending_ops.insert(pending_ops.size(), op);
      if ((kind == deq_pkg::KIND_PUSH_FRONT || kind == deq_pkg::KIND_PUSH_BACK) &&
          planned_count < QUEUE_DEPTH)
         planned_count++;
      else if ((kind == deq_pkg::KIND_POP_FRONT || kind == deq_pkg::KIND_POP_BACK) &&
               planned_count > 0)
         planned_count--;
   endtask

   function automatic logic [31:0] random_word();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0)
         return '0;
      else if (pick == 1)
         return '1;
      return $urandom;
   endfunction

   task automatic add_random_ops(input int n, input int push_pct);
      int pick;
      kind_type kind;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < push_pct)
            kind = pick[0] ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_BACK;
         else if (pick < 92)
            kind = pick[0] ? deq_pkg::KIND_POP_FRONT : deq_pkg::KIND_POP_BACK;
         else
            kind = kind_type'($urandom_range(4, 7));
         add_op(kind, random_word(), 1'b0);
      end
   endtask

   // Sender: one word is offered at a time and held until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !word_taken) begin
         // Stalled word stays on the bus unchanged.
      end else begin
         tail_quiet = pending_ops.size() < 60;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_ops.size() == 0 ||
                      (pending_ops[0].wait_drain && expected_results.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (send_bursty && !tail_quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else begin
            next_op = pending_ops[0];
            pending_ops.delete(0);
            req_kind <= next_op.kind;
            req_value <= next_op.value;
            req_valid <= 1'b1;
         end
      end
   end

   // Receiver: random stall bursts plus one long hold-off that backs the
   // block up until it stalls its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
         long_hold_done = 1'b1;
         hold_left = 399;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (recv_bursty && !tail_quiet && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: checks result words and predicts each accepted input word.
   always @(posedge clock) begin
      word_taken = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (results_seen % 100 == 0)
               recv_bursty = $urandom_range(0, 3) != 0;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", 32'(rsp_count), 32'd0);
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp_popped_value !== want.popped_value)
                  report_mismatch("popped_value", rsp_popped_value, want.popped_value);
               if (rsp_popped_valid !== want.popped_valid)
                  report_mismatch("popped_valid", 32'(rsp_popped_valid), 32'(want.popped_valid));
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_count !== want.count)
                  report_mismatch("count", 32'(rsp_count), 32'(want.count));
               if (rsp_is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_is_empty), 32'(want.is_empty));
               if (rsp_front_value !== want.front_value)
                  report_mismatch("front_value", rsp_front_value, want.front_value);
               if (rsp_back_value !== want.back_value)
                  report_mismatch("back_value", rsp_back_value, want.back_value);
            end
         end
         if (word_taken) begin
            words_sent++;
            if (words_sent % 100 == 0)
               send_bursty = $urandom_range(0, 3) != 0;
            expected_results.insert(expected_results.size(),
                                    apply_deque_op(req_kind, req_value));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_results.size());
         $display("** double_ended_queue: FAILED **");
         $finish;
      end
   end

   initial begin
      // Directed: empty queries and pops, extreme words, every kind code,
      // both pop ends down to empty, and the head wrapping below slot zero.
      add_op(KIND_QUERY, '1, 1'b0);
      add_op(deq_pkg::KIND_POP_FRONT, $urandom, 1'b0);
      add_op(deq_pkg::KIND_POP_BACK, $urandom, 1'b0);
      add_op(deq_pkg::KIND_PUSH_FRONT, '0, 1'b0);
      add_op(deq_pkg::KIND_POP_BACK, '1, 1'b0);
      add_op(deq_pkg::KIND_PUSH_BACK, '1, 1'b0);
      add_op(deq_pkg::KIND_PUSH_FRONT, '0, 1'b0);
      add_op(deq_pkg::KIND_PUSH_BACK, 32'hAAAA_AAAA, 1'b0);
      add_op(deq_pkg::KIND_PUSH_FRONT, 32'h5555_5555, 1'b0);
      for (int k = 5; k <= 7; k++)
         add_op(kind_type'(k), $urandom, 1'b0);
      add_op(deq_pkg::KIND_POP_BACK, '0, 1'b0);
      add_op(deq_pkg::KIND_POP_FRONT, '0, 1'b0);
      add_op(deq_pkg::KIND_POP_BACK, '0, 1'b0);
      add_op(deq_pkg::KIND_POP_FRONT, '0, 1'b0);
      add_op(deq_pkg::KIND_POP_FRONT, '1, 1'b0);
      add_op(deq_pkg::KIND_PUSH_BACK, 32'h0000_0001, 1'b0);
      add_op(deq_pkg::KIND_PUSH_BACK, 32'h8000_0000, 1'b0);
      add_op(deq_pkg::KIND_POP_FRONT, '0, 1'b0);
      add_op(deq_pkg::KIND_POP_FRONT, '0, 1'b0);
      add_op(deq_pkg::KIND_POP_BACK, '0, 1'b0);

      add_random_ops(200, 56);

      // Build up from both ends, mix in some traffic, then empty it.
      add_op(KIND_QUERY, $urandom, 1'b1);
      repeat (60)
         add_op($urandom_range(0, 1) ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_BACK,
                random_word(), 1'b0);
      add_op(KIND_QUERY, $urandom, 1'b0);
      add_op(deq_pkg::KIND_POP_BACK, '0, 1'b0);
      add_op(deq_pkg::KIND_PUSH_BACK, '1, 1'b0);
      add_random_ops(40, 50);
      while (planned_count > 0)
         add_op($urandom_range(0, 1) ? deq_pkg::KIND_POP_FRONT : deq_pkg::KIND_POP_BACK,
                $urandom, 1'b0);
      add_op(deq_pkg::KIND_POP_BACK, $urandom, 1'b0);

      add_op(KIND_QUERY, $urandom, 1'b1);
      add_random_ops(130, 46);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(pending_ops.size() == 0 && !req_valid && expected_results.size() == 0))
         @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Sent %0d words: %0d pushes, %0d pops, %0d empty pops, %0d dropped pushes.",
               words_sent, push_hits, pop_hits, underflow_hits, overflow_hits);
      $display("Peak occupancy %0d of %0d, %0d mismatches in %0d cycles.",
               peak_count, QUEUE_DEPTH, error_count, cycle_count);
      if (error_count == 0)
         $display("** double_ended_queue: PASSED **");
      else
         $display("** double_ended_queue: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
